FILE: sv/pdlf_pkg.sv
package pdlf_pkg;

	localparam int SensorW = 10;
	localparam int PosW    = 12;
	localparam int SpeedW  = 9;
	localparam int GainW   = 10;
	localparam int ErrW    = 13;
	localparam int DiffW   = 14;
	localparam int ProdW   = 24;
	localparam int CorrW   = 17;
	localparam int SumW    = 18;
	localparam int CfgW    = 10;

	// both queues: four entries
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	localparam logic [SensorW-1:0] FullScale = 10'd1000;
	localparam logic [SensorW-1:0] FlagLevel = 10'd700;
	localparam logic [SensorW-1:0] LostLevel = 10'd600;
	localparam logic [PosW-1:0]    MidPoint  = 12'd2000;
	localparam int                 GainShift = 8;
	localparam logic [ProdW-1:0]   GainRound = 24'd255;

	// floor(x * 7 / 10) == (x * 7 * 3277) >> 15 for x * 7 below 16384
	localparam logic [ProdW-1:0] FloorMul   = 24'd22939;
	localparam int               FloorShift = 15;

	localparam logic [SpeedW-1:0] BaseSpeedReset = 9'd60;
	localparam logic [GainW-1:0]  PropGainReset  = 10'd64;
	localparam logic [GainW-1:0]  DerivGainReset = 10'd256;

	typedef enum logic [1:0] {
		REG_BASE_SPEED = 2'd0,
		REG_PROP_GAIN  = 2'd1,
		REG_DERIV_GAIN = 2'd2,
		REG_WHITE_LINE = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		END_NONE = 2'd0,
		END_LOST = 2'd1,
		END_SIDE = 2'd2
	} end_kind_t;

	typedef struct packed {
		logic [SensorW-1:0] sensor_left;
		logic [SensorW-1:0] sensor_inner_left;
		logic [SensorW-1:0] sensor_middle;
		logic [SensorW-1:0] sensor_inner_right;
		logic [SensorW-1:0] sensor_right;
		logic [PosW-1:0]    line_position;
	} sample_t;

	typedef struct packed {
		logic [SpeedW-1:0] left_speed;
		logic [SpeedW-1:0] right_speed;
		logic              left_seen;
		logic              center_seen;
		logic              right_seen;
		end_kind_t         end_kind;
	} result_t;

	typedef struct packed {
		logic [SpeedW-1:0] base_speed;
		logic [SpeedW-1:0] speed_floor;
		logic [GainW-1:0]  prop_gain;
		logic [GainW-1:0]  deriv_gain;
		logic              white_line;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic signed [ErrW-1:0]  err;
		logic signed [DiffW-1:0] diff;
		logic                    left_seen;
		logic                    center_seen;
		logic                    right_seen;
		end_kind_t               end_kind;
	} cmd_t;

	function automatic logic [SensorW-1:0] sense(input logic [SensorW-1:0] raw,
		input logic white);
		logic [SensorW-1:0] v;
		v = (raw > FullScale) ? FullScale : raw;
		return white ? (FullScale - v) : v;
	endfunction

	function automatic logic [SpeedW-1:0] speed_floor(input logic [SpeedW-1:0] base);
		logic [ProdW-1:0] p;
		p = ProdW'(base) * FloorMul;
		return p[FloorShift +: SpeedW];
	endfunction

	// signed product / 256, rounded toward zero
	function automatic logic signed [CorrW-1:0] gain_div(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-1:0] pa;
		logic signed [ProdW-1:0] q;
		pa = p + (p[ProdW-1] ? GainRound : '0);
		q = pa >>> GainShift;
		return CorrW'(q);
	endfunction

	function automatic logic [SpeedW-1:0] clamp_speed(input logic signed [SumW-1:0] v,
		input logic [SpeedW-1:0] lo, input logic [SpeedW-1:0] hi);
		logic signed [SumW-1:0] lo_s;
		logic signed [SumW-1:0] hi_s;
		lo_s = $signed({{(SumW-SpeedW){1'b0}}, lo});
		hi_s = $signed({{(SumW-SpeedW){1'b0}}, hi});
		if (v < lo_s) begin
			return lo;
		end else if (v > hi_s) begin
			return hi;
		end
		return v[SpeedW-1:0];
	endfunction

endpackage

FILE: sv/pdlf_front.sv
module pdlf_front
	import pdlf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  sample_t sample,
	input  logic    white_line,
	output logic    cmd_valid,
	output cmd_t    cmd,
	input  logic    cmd_pop
);

	cmd_t                   cmd_q [QDepth];
	logic [QPtrW-1:0]       wr_ptr_q;
	logic [QPtrW-1:0]       rd_ptr_q;
	logic [QCntW-1:0]       count_q;
	logic signed [ErrW-1:0] last_error_q;

	logic [SensorW-1:0]     s_left, s_inl, s_mid, s_inr, s_right;
	logic                   accept;
	logic                   take;
	cmd_t                   cmd_new;

	always_comb begin
		s_left  = sense(sample.sensor_left, white_line);
		s_inl   = sense(sample.sensor_inner_left, white_line);
		s_mid   = sense(sample.sensor_middle, white_line);
		s_inr   = sense(sample.sensor_inner_right, white_line);
		s_right = sense(sample.sensor_right, white_line);

		cmd_new.left_seen   = s_left > FlagLevel;
		cmd_new.center_seen = s_mid > FlagLevel;
		cmd_new.right_seen  = s_right > FlagLevel;

		cmd_new.err  = $signed({1'b0, sample.line_position}) - $signed({1'b0, MidPoint});
		cmd_new.diff = $signed({cmd_new.err[ErrW-1], cmd_new.err})
			- $signed({last_error_q[ErrW-1], last_error_q});

		// line lost wins over a side branch
		if (!cmd_new.center_seen && s_inl < LostLevel && s_inr < LostLevel) begin
			cmd_new.end_kind = END_LOST;
		end else if (cmd_new.left_seen || cmd_new.right_seen) begin
			cmd_new.end_kind = END_SIDE;
		end else begin
			cmd_new.end_kind = END_NONE;
		end
	end

	assign full      = count_q == QCntW'(QDepth);
	assign cmd_valid = count_q != '0;
	assign cmd       = cmd_q[rd_ptr_q];
	assign accept    = push && !full;
	assign take      = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
			last_error_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q     <= wr_ptr_q + 1'b1;
				last_error_q <= (cmd_new.end_kind == END_NONE) ? cmd_new.err : '0;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !accept) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

FILE: sv/pdlf_back.sv
module pdlf_back
	import pdlf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic                     v_s1, v_s2;
	logic signed [ProdW-1:0]  prod_p_s1, prod_d_s1;
	cmd_t                     cmd_s1, cmd_s2;
	logic signed [CorrW-1:0]  corr_s2;

	result_t                  res_q [QDepth];
	logic [QPtrW-1:0]         wr_ptr_q;
	logic [QPtrW-1:0]         rd_ptr_q;
	logic [QCntW-1:0]         count_q;

	logic [QCntW-1:0]         in_flight;
	logic                     take_out;
	logic signed [SumW-1:0]   base_s, corr_x;
	result_t                  res_new;

	// only pull a transaction when the result queue has room for everything in flight
	assign in_flight = count_q + QCntW'(v_s1) + QCntW'(v_s2);
	assign cmd_pop   = cmd_valid && (in_flight < QCntW'(QDepth));
	assign empty     = count_q == '0;
	assign result    = res_q[rd_ptr_q];
	assign take_out  = pop && !empty;

	always_comb begin
		base_s = $signed({{(SumW-SpeedW){1'b0}}, cfg.base_speed});
		corr_x = $signed({{(SumW-CorrW){corr_s2[CorrW-1]}}, corr_s2});
		res_new.left_speed  = clamp_speed(base_s + corr_x, cfg.speed_floor, cfg.base_speed);
		res_new.right_speed = clamp_speed(base_s - corr_x, cfg.speed_floor, cfg.base_speed);
		res_new.left_seen   = cmd_s2.left_seen;
		res_new.center_seen = cmd_s2.center_seen;
		res_new.right_seen  = cmd_s2.right_seen;
		res_new.end_kind    = cmd_s2.end_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1;
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take_out) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (v_s2 && !take_out) begin
				count_q <= count_q + 1'b1;
			end else if (take_out && !v_s2) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1    <= cmd;
			prod_p_s1 <= ProdW'(cmd.err) * $signed({{(ProdW-GainW){1'b0}}, cfg.prop_gain});
			prod_d_s1 <= ProdW'(cmd.diff) * $signed({{(ProdW-GainW){1'b0}}, cfg.deriv_gain});
		end
		if (v_s1) begin
			cmd_s2  <= cmd_s1;
			corr_s2 <= gain_div(prod_p_s1) + gain_div(prod_d_s1);
		end
		if (v_s2) begin
			res_q[wr_ptr_q] <= res_new;
		end
	end

endmodule

FILE: sv/pd_line_follow_steering.sv
// PD steering for a five-sensor line follower. Each sample pushed in gives exactly one
// result, in order: both wheel speeds clamped to [floor(base*7/10), base], the outer-left,
// center and outer-right line flags, and whether the segment ends (line lost or side
// branch). One sample is taken per clock unless full is high; between the front queue
// and the result queue, the back end has a multiply stage and a correction stage. Each
// queue has four entries, so the block keeps taking samples while results
// wait to be popped until both queues fill. The previous error used by the derivative
// term is updated as each sample is pushed and is cleared after a segment end.
// Configuration writes are always ready and must only happen while no sample is pending.
module pd_line_follow_steering
	import pdlf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sample_t           sample,
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  reg_index_t        cfg_index,
	input  logic [CfgW-1:0]   cfg_data
);

	cfg_t cfg_q;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed  <= BaseSpeedReset;
			cfg_q.speed_floor <= speed_floor(BaseSpeedReset);
			cfg_q.prop_gain   <= PropGainReset;
			cfg_q.deriv_gain  <= DerivGainReset;
			cfg_q.white_line  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE_SPEED: begin
					cfg_q.base_speed  <= cfg_data[SpeedW-1:0];
					cfg_q.speed_floor <= speed_floor(cfg_data[SpeedW-1:0]);
				end
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[GainW-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[GainW-1:0];
				REG_WHITE_LINE: cfg_q.white_line <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pdlf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.white_line (cfg_q.white_line),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	pdlf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: tb/sv/pd_line_follow_steering_tb.sv
module pd_line_follow_steering_tb;
	import pdlf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SENSE_MAX   = 1000;
	localparam int SEEN_LEVEL  = 700;
	localparam int LOST_LEVEL  = 600;
	localparam int GAIN_UNIT   = 256;
	localparam int CENTER_POS  = 2000;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASE_ITEMS = 230;

	localparam result_t NO_RESULT = '{9'd0, 9'd0, 1'b0, 1'b0, 1'b0, END_NONE};

	typedef struct {
		sample_t s;
		bit      typed;
		result_t want;
	} plan_row_t;

	logic            clk;
	logic            arst_n;
	logic            push;
	logic            full;
	sample_t         sample;
	logic            empty;
	logic            pop;
	result_t         result;
	logic            cfg_valid;
	logic            cfg_ready;
	reg_index_t      cfg_index;
	logic [CfgW-1:0] cfg_data;

	// shadow of the steering registers and the derivative history
	int cfg_base;
	int cfg_kp;
	int cfg_kd;
	int cfg_white;
	int prev_err;

	result_t   steer_due_q[$];
	plan_row_t plan[$];
	bit        row_typed;
	result_t   row_want;
	int        bad_steer;
	bit        tx_burst;
	bit        rx_burst;
	bit        hold_req;

	pd_line_follow_steering dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("pd_line_follow_steering verification failed");
		$finish;
	end

	function automatic int sensed(input logic [SensorW-1:0] raw);
		int v;
		v = (int'(raw) > SENSE_MAX) ? SENSE_MAX : int'(raw);
		return cfg_white ? SENSE_MAX - v : v;
	endfunction

	function automatic int clamp_wheel(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic result_t steer_predict(input sample_t s);
		int il;
		int mid;
		int ir;
		int err;
		int corr;
		int lo;
		result_t o;
		il  = sensed(s.sensor_inner_left);
		mid = sensed(s.sensor_middle);
		ir  = sensed(s.sensor_inner_right);
		o.left_seen   = sensed(s.sensor_left) > SEEN_LEVEL;
		o.center_seen = mid > SEEN_LEVEL;
		o.right_seen  = sensed(s.sensor_right) > SEEN_LEVEL;
		err  = int'(s.line_position) - CENTER_POS;
		// sv integer division truncates toward zero
		corr = (err * cfg_kp) / GAIN_UNIT + ((err - prev_err) * cfg_kd) / GAIN_UNIT;
		lo   = (cfg_base * 7) / 10;
		o.left_speed  = SpeedW'(clamp_wheel(cfg_base + corr, lo, cfg_base));
		o.right_speed = SpeedW'(clamp_wheel(cfg_base - corr, lo, cfg_base));
		if (!o.center_seen && il < LOST_LEVEL && ir < LOST_LEVEL) begin
			o.end_kind = END_LOST;
		end else if (o.left_seen || o.right_seen) begin
			o.end_kind = END_SIDE;
		end else begin
			o.end_kind = END_NONE;
		end
		prev_err = (o.end_kind == END_NONE) ? err : 0;
		return o;
	endfunction

	function automatic sample_t reading(input int l, input int il, input int m, input int ir,
		input int r, input int pos);
		return '{SensorW'(l), SensorW'(il), SensorW'(m), SensorW'(ir), SensorW'(r), PosW'(pos)};
	endfunction

	// mostly well-formed line samples, some lost, some side branches, rest noise
	function automatic sample_t gen_sample();
		int kind;
		int v[5];
		int pos;
		int i;
		kind = $urandom_range(0, 99);
		for (i = 0; i < 5; i++) v[i] = $urandom_range(0, SENSE_MAX);
		pos = $urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom_range(1900, 2100);
		if (kind < 60) begin
			v[2] = $urandom_range(SEEN_LEVEL + 1, SENSE_MAX);
			v[0] = $urandom_range(0, SEEN_LEVEL);
			v[4] = $urandom_range(0, SEEN_LEVEL);
		end else if (kind < 75) begin
			v[2] = $urandom_range(0, SEEN_LEVEL);
			v[1] = $urandom_range(0, LOST_LEVEL - 1);
			v[3] = $urandom_range(0, LOST_LEVEL - 1);
		end else if (kind < 90) begin
			v[2] = $urandom_range(SEEN_LEVEL + 1, SENSE_MAX);
			if ($urandom_range(0, 1)) begin
				v[0] = $urandom_range(SEEN_LEVEL + 1, SENSE_MAX);
			end else begin
				v[4] = $urandom_range(SEEN_LEVEL + 1, SENSE_MAX);
			end
		end
		if (kind < 90 && cfg_white) begin
			for (i = 0; i < 5; i++) v[i] = SENSE_MAX - v[i];
		end
		if (kind >= 90) begin
			for (i = 0; i < 5; i++) v[i] = $urandom_range(0, 1023);
			pos = $urandom_range(0, 4095);
		end
		return reading(v[0], v[1], v[2], v[3], v[4], pos);
	endfunction

	always @(posedge clk) begin : scoreboard
		result_t want;
		if (arst_n && pop && !empty) begin
			if (steer_due_q.size() == 0) begin
				bad_steer++;
				if (bad_steer <= 10) $display("unexpected result transaction: %p", result);
			end else begin
				want = steer_due_q.pop_front();
				if (result.left_speed !== want.left_speed || result.right_speed !== want.right_speed
					|| result.left_seen !== want.left_seen
					|| result.center_seen !== want.center_seen
					|| result.right_seen !== want.right_seen
					|| result.end_kind !== want.end_kind) begin
					bad_steer++;
					if (bad_steer <= 10) begin
						$display("mismatch at %0t: expected speeds %0d/%0d seen %b%b%b end %0d",
							$realtime, want.left_speed, want.right_speed, want.left_seen,
							want.center_seen, want.right_seen, want.end_kind);
						$display("                  actual speeds %0d/%0d seen %b%b%b end %0d",
							result.left_speed, result.right_speed, result.left_seen,
							result.center_seen, result.right_seen, result.end_kind);
					end
				end
			end
		end
		if (arst_n && push && !full) begin
			want = steer_predict(sample);
			steer_due_q.push_back(row_typed ? row_want : want);
		end
	end

	// result side: random pops, a burst mode now and then, one long hold-off on request
	initial begin : drain_side
		int gap;
		pop      = 1'b0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 59) == 0) rx_burst = ~rx_burst;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, 3);
			end
			repeat (gap) @(negedge clk) pop <= 1'b0;
			@(negedge clk) pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	task automatic offer(input sample_t s, input bit typed, input result_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 3);
		repeat (gap) @(negedge clk) push <= 1'b0;
		@(negedge clk);
		push      <= 1'b1;
		sample    <= s;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input int value);
		logic [CfgW-1:0] d;
		d = CfgW'(value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BASE_SPEED: cfg_base  = int'(d[SpeedW-1:0]);
			REG_PROP_GAIN:  cfg_kp    = int'(d[GainW-1:0]);
			REG_DERIV_GAIN: cfg_kd    = int'(d[GainW-1:0]);
			REG_WHITE_LINE: cfg_white = int'(d[0]);
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// wait out every pending result plus the pipeline depth
	task automatic settle();
		while (steer_due_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input int base, input int kp, input int kd, input int white,
		input bit burst, input bit hold);
		@(negedge clk) push <= 1'b0;
		settle();
		write_reg(REG_BASE_SPEED, base);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_WHITE_LINE, white);
		tx_burst = burst;
		if (hold) hold_req = 1'b1;
		repeat (PHASE_ITEMS) offer(gen_sample(), 1'b0, NO_RESULT);
	endtask

	initial begin : stimulus
		int i;
		arst_n    = 1'b0;
		push      = 1'b0;
		sample    = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_SPEED;
		cfg_data  = '0;
		row_typed = 1'b0;
		row_want  = NO_RESULT;
		hold_req  = 1'b0;
		tx_burst  = 1'b0;
		bad_steer = 0;
		cfg_base  = 60;
		cfg_kp    = 64;
		cfg_kd    = 256;
		cfg_white = 0;
		prev_err  = 0;

		// reset gains: base 60, floor 42
		plan.push_back('{reading(0, 0, 0, 0, 0, 2000), 1'b1,
			'{9'd60, 9'd60, 1'b0, 1'b0, 1'b0, END_LOST}});
		plan.push_back('{reading(1000, 1000, 1000, 1000, 1000, 2000), 1'b1,
			'{9'd60, 9'd60, 1'b1, 1'b1, 1'b1, END_SIDE}});
		plan.push_back('{reading(0, 0, 1000, 0, 0, 4000), 1'b1,
			'{9'd60, 9'd42, 1'b0, 1'b1, 1'b0, END_NONE}});
		plan.push_back('{reading(0, 0, 1000, 0, 0, 0), 1'b1,
			'{9'd42, 9'd60, 1'b0, 1'b1, 1'b0, END_NONE}});
		// position beyond full travel
		plan.push_back('{reading(0, 0, 1000, 0, 0, 4095), 1'b0, NO_RESULT});
		// saturated raw values
		plan.push_back('{reading(1023, 1023, 1023, 1023, 1023, 2000), 1'b0, NO_RESULT});
		plan.push_back('{reading(1001, 1022, 1012, 1001, 1020, 2100), 1'b0, NO_RESULT});
		// threshold edges for lost line and branch flags
		plan.push_back('{reading(0, 599, 700, 599, 0, 1990), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 0, 701, 0, 0, 2010), 1'b0, NO_RESULT});
		plan.push_back('{reading(701, 600, 700, 0, 0, 2020), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 0, 0, 600, 700, 1980), 1'b0, NO_RESULT});
		// lost line wins over a side flag
		plan.push_back('{reading(701, 0, 0, 0, 701, 2500), 1'b0, NO_RESULT});
		// small errors exercise truncation toward zero both ways
		plan.push_back('{reading(0, 300, 900, 300, 0, 2001), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 300, 900, 300, 0, 1999), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 300, 900, 300, 0, 2003), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 300, 900, 300, 0, 1997), 1'b0, NO_RESULT});
		plan.push_back('{reading(512, 256, 768, 128, 64, 2731), 1'b0, NO_RESULT});
		plan.push_back('{reading(0, 0, 1000, 0, 0, 1365), 1'b0, NO_RESULT});

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (i = 0; i < plan.size(); i++) offer(plan[i].s, plan[i].typed, plan[i].want);

		run_phase(60, 64, 256, 0, 1'b0, 1'b0);
		run_phase(0, 0, 0, 0, 1'b1, 1'b0);
		run_phase(400, 1023, 1023, 1, 1'b1, 1'b1);
		run_phase(10'h3FF, 1023, 0, 0, 1'b0, 1'b0);
		run_phase(400, 0, 1023, 1, 1'b0, 1'b0);
		run_phase($urandom_range(0, 400), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1), 1'b0, 1'b0);
		run_phase($urandom_range(0, 400), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1), 1'b1, 1'b0);
		run_phase($urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1), 1'b0, 1'b0);

		@(negedge clk) push <= 1'b0;
		settle();
		if (bad_steer == 0 && steer_due_q.size() == 0) begin
			$display("pd_line_follow_steering verification clean");
		end else begin
			$display("pd_line_follow_steering verification failed");
		end
		$finish;
	end

endmodule
